// ===== sv/pbec_pkg.sv =====
// ----------------------------------------------------------------------------
// Page bitmap erase/copy command package
// Shared constants, codes, queue entry and command types for the block.
// ----------------------------------------------------------------------------
package pbec_pkg;

    localparam int ADDR_W           = 32;
    localparam int PAGE_BYTES       = 4096;
    localparam int MAX_BITMAP_BYTES = 8192;
    localparam int BITS             = 8;
    localparam int PAGE_SHIFT       = $clog2(PAGE_BYTES);
    localparam int SPAGE_W          = ADDR_W - PAGE_SHIFT;
    localparam int BCNT_W           = $clog2(MAX_BITMAP_BYTES + 1);
    localparam int BIT_W            = $clog2(BITS);
    localparam int PAGE_W           = BCNT_W + BIT_W;
    localparam int CMP_W            = (PAGE_W > SPAGE_W) ? PAGE_W : SPAGE_W;
    localparam int STEP_W           = BIT_W + 1;
    localparam int REG_IDX_W        = 2;

    localparam logic OP_ERASE  = 1'b0;
    localparam logic OP_COPY   = 1'b1;
    localparam logic CMD_ERASE = 1'b0;
    localparam logic CMD_COPY  = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_REGION_START = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_REGION_END   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COPY_SOURCE  = 2'd2;

    localparam logic [ADDR_W-1:0] PAGE_LEN = ADDR_W'(PAGE_BYTES);

    // Masks are indexed by step: step 0 is bit 7 of the bitmap byte.
    // Bit BITS of emit_mask marks the final run flush.
    typedef struct packed {
        logic              op;
        logic              first;
        logic [BITS-1:0]   set_mask;
        logic [BITS-1:0]   ins_mask;
        logic [BITS-1:0]   start_mask;
        logic [BITS:0]     emit_mask;
        logic [BCNT_W-1:0] byte_idx;
    } entry_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] target;
        logic [ADDR_W-1:0] source;
        logic [ADDR_W-1:0] length;
        logic              last;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_W-1:0] page);
        return ADDR_W'(page) << PAGE_SHIFT;
    endfunction

endpackage

// ===== sv/pbec_item_if.sv =====
// ----------------------------------------------------------------------------
// Bitmap byte channel
// Valid/ready channel that carries one bitmap byte per transaction.
// ----------------------------------------------------------------------------
interface pbec_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] bitmap_byte;
    logic       last_byte;

    modport source (output valid, output opcode, output bitmap_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input opcode, input bitmap_byte, input last_byte,
                    output ready);
endinterface

// ===== sv/pbec_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Flash command channel
// Valid/ready channel that carries one flash command per transaction.
// ----------------------------------------------------------------------------
interface pbec_cmd_if;
    logic                        valid;
    logic                        ready;
    logic                        command_kind;
    logic [pbec_pkg::ADDR_W-1:0] target_addr;
    logic [pbec_pkg::ADDR_W-1:0] source_addr;
    logic [pbec_pkg::ADDR_W-1:0] erase_length;
    logic                        last_of_item;

    modport source (output valid, output command_kind, output target_addr,
                    output source_addr, output erase_length, output last_of_item,
                    input ready);
    modport sink   (input valid, input command_kind, input target_addr,
                    input source_addr, input erase_length, input last_of_item,
                    output ready);
endinterface

// ===== sv/pbec_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes one register per transaction.
// ----------------------------------------------------------------------------
interface pbec_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pbec_pkg::REG_IDX_W-1:0] addr;
    logic [pbec_pkg::ADDR_W-1:0]    data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== sv/pbec_front.sv =====
// ----------------------------------------------------------------------------
// Bitmap byte classifier
// Accepts bitmap bytes, tracks the pass position and open erase run, and
// marks for each page bit whether it starts a run or issues a command.
// ----------------------------------------------------------------------------
module pbec_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    pbec_item_if.sink                      item,
    input  logic [pbec_pkg::SPAGE_W-1:0]   start_page,
    input  logic [pbec_pkg::SPAGE_W-1:0]   end_page,
    output logic                           push_valid,
    input  logic                           push_ready,
    output pbec_pkg::entry_t               push_entry
);

    logic [pbec_pkg::BCNT_W-1:0] bcnt_reg;
    logic [pbec_pkg::BCNT_W-1:0] bcnt_next;
    logic                        run_open_reg;
    logic                        run_open_next;
    logic                        first;
    logic                        in_range;
    logic                        accept;

    assign accept     = item.valid && push_ready;
    assign item.ready = push_ready;
    assign push_valid = item.valid;
    assign first      = (bcnt_reg == '0);
    assign in_range   = (bcnt_reg < pbec_pkg::BCNT_W'(pbec_pkg::MAX_BITMAP_BYTES));

    always_comb
    begin : classify
        logic                        open_v;
        logic                        set_v;
        logic                        ins_v;
        logic [pbec_pkg::PAGE_W-1:0] page_v;
        open_v                = first ? 1'b0 : run_open_reg;
        push_entry            = '0;
        push_entry.op         = item.opcode;
        push_entry.first      = first;
        push_entry.byte_idx   = bcnt_reg;
        for (int k = 0; k < pbec_pkg::BITS; k++)
        begin
            page_v = {bcnt_reg, pbec_pkg::BIT_W'(k)};
            set_v  = item.bitmap_byte[pbec_pkg::BITS-1-k] && in_range;
            ins_v  = in_range
                     && (pbec_pkg::CMP_W'(page_v) >= pbec_pkg::CMP_W'(start_page))
                     && (pbec_pkg::CMP_W'(page_v) <  pbec_pkg::CMP_W'(end_page));
            push_entry.set_mask[k] = set_v;
            push_entry.ins_mask[k] = ins_v;
            if (item.opcode == pbec_pkg::OP_COPY)
            begin
                push_entry.emit_mask[k] = set_v && ins_v;
            end
            else if (ins_v)
            begin
                if (set_v && !open_v)
                begin
                    push_entry.start_mask[k] = 1'b1;
                    open_v = 1'b1;
                end
                else if (!set_v && open_v)
                begin
                    push_entry.emit_mask[k] = 1'b1;
                    open_v = 1'b0;
                end
            end
        end
        push_entry.emit_mask[pbec_pkg::BITS] =
            item.last_byte && (item.opcode == pbec_pkg::OP_ERASE) && open_v;
        run_open_next = item.last_byte ? 1'b0 : open_v;
    end

    always_comb
    begin
        if (item.last_byte)
        begin
            bcnt_next = '0;
        end
        else if (in_range)
        begin
            bcnt_next = bcnt_reg + pbec_pkg::BCNT_W'(1);
        end
        else
        begin
            bcnt_next = bcnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg     <= '0;
            run_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            bcnt_reg     <= bcnt_next;
            run_open_reg <= run_open_next;
        end
    end

endmodule

// ===== sv/pbec_queue.sv =====
// ----------------------------------------------------------------------------
// Classified byte queue
// Two-entry queue that decouples the classifier from the command issuer.
// ----------------------------------------------------------------------------
module pbec_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  pbec_pkg::entry_t push_entry,
    output logic             head_valid,
    input  logic             head_pop,
    output pbec_pkg::entry_t head
);

    pbec_pkg::entry_t mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/pbec_back.sv =====
// ----------------------------------------------------------------------------
// Flash command issuer
// Walks the page bits of each classified byte, one per cycle unless the
// cmd channel stalls, keeps the copy addresses and run start, and issues
// commands through an output register.
// ----------------------------------------------------------------------------
module pbec_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  pbec_pkg::entry_t             head,
    output logic                         head_pop,
    input  logic [pbec_pkg::ADDR_W-1:0]  region_start,
    input  logic [pbec_pkg::ADDR_W-1:0]  region_end,
    input  logic [pbec_pkg::ADDR_W-1:0]  copy_source,
    pbec_cmd_if.source                   cmd
);

    localparam logic [pbec_pkg::BIT_W-1:0] BIT_LAST = pbec_pkg::BIT_W'(pbec_pkg::BITS - 1);

    logic [pbec_pkg::STEP_W-1:0] step_reg;
    logic [pbec_pkg::STEP_W-1:0] step_next;
    logic [pbec_pkg::ADDR_W-1:0] dest_reg;
    logic [pbec_pkg::ADDR_W-1:0] dest_next;
    logic [pbec_pkg::ADDR_W-1:0] src_reg;
    logic [pbec_pkg::ADDR_W-1:0] src_next;
    logic [pbec_pkg::PAGE_W-1:0] run_start_reg;
    logic [pbec_pkg::PAGE_W-1:0] run_start_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    pbec_pkg::cmd_t              out_cmd_reg;
    pbec_pkg::cmd_t              new_cmd;

    logic [pbec_pkg::BIT_W-1:0]  bit_idx;
    logic                        flush_step;
    logic                        advance;
    logic                        emit_now;
    logic                        end_item;
    logic                        later;
    logic                        load_base;
    logic [pbec_pkg::ADDR_W-1:0] dest_cur;
    logic [pbec_pkg::ADDR_W-1:0] src_cur;
    logic [pbec_pkg::ADDR_W-1:0] run_addr;
    logic [pbec_pkg::PAGE_W-1:0] page;

    assign bit_idx    = step_reg[pbec_pkg::BIT_W-1:0];
    assign flush_step = step_reg[pbec_pkg::BIT_W];
    assign advance    = head_valid && (!out_valid_reg || cmd.ready);
    assign load_base  = head.first && (step_reg == '0);
    assign dest_cur   = load_base ? region_start : dest_reg;
    assign src_cur    = load_base ? copy_source : src_reg;
    assign page       = {head.byte_idx, bit_idx};
    assign run_addr   = pbec_pkg::page_addr(run_start_reg);
    assign emit_now   = flush_step ? head.emit_mask[pbec_pkg::BITS] : head.emit_mask[bit_idx];
    assign end_item   = flush_step
                        || ((bit_idx == BIT_LAST) && !head.emit_mask[pbec_pkg::BITS]);
    assign head_pop   = advance && end_item;

    always_comb
    begin
        later = 1'b0;
        for (int j = 0; j <= pbec_pkg::BITS; j++)
        begin
            if (j > int'(step_reg))
            begin
                later = later | head.emit_mask[j];
            end
        end
    end

    always_comb
    begin
        new_cmd      = '0;
        new_cmd.last = !later;
        if (flush_step)
        begin
            new_cmd.kind   = pbec_pkg::CMD_ERASE;
            new_cmd.target = run_addr;
            new_cmd.length = region_end - run_addr;
        end
        else if (head.op == pbec_pkg::OP_COPY)
        begin
            new_cmd.kind   = pbec_pkg::CMD_COPY;
            new_cmd.target = dest_cur;
            new_cmd.source = src_cur;
            new_cmd.length = pbec_pkg::PAGE_LEN;
        end
        else
        begin
            new_cmd.kind   = pbec_pkg::CMD_ERASE;
            new_cmd.target = run_addr;
            new_cmd.length = pbec_pkg::page_addr(page - run_start_reg);
        end
    end

    always_comb
    begin
        dest_next      = dest_reg;
        src_next       = src_reg;
        run_start_next = run_start_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            step_next = end_item ? '0 : step_reg + pbec_pkg::STEP_W'(1);
            if (!flush_step)
            begin
                dest_next = dest_cur;
                src_next  = src_cur;
                if (head.op == pbec_pkg::OP_COPY)
                begin
                    if (head.ins_mask[bit_idx])
                    begin
                        dest_next = dest_cur + pbec_pkg::PAGE_LEN;
                    end
                    if (head.set_mask[bit_idx])
                    begin
                        src_next = src_cur + pbec_pkg::PAGE_LEN;
                    end
                end
                else if (head.start_mask[bit_idx])
                begin
                    run_start_next = page;
                end
            end
        end
        if (advance && emit_now)
        begin
            out_valid_next = 1'b1;
        end
        else if (cmd.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg      <= dest_next;
        src_reg       <= src_next;
        run_start_reg <= run_start_next;
        if (advance && emit_now)
        begin
            out_cmd_reg <= new_cmd;
        end
    end

    assign cmd.valid        = out_valid_reg;
    assign cmd.command_kind = out_cmd_reg.kind;
    assign cmd.target_addr  = out_cmd_reg.target;
    assign cmd.source_addr  = out_cmd_reg.source;
    assign cmd.erase_length = out_cmd_reg.length;
    assign cmd.last_of_item = out_cmd_reg.last;

endmodule

// ===== sv/page_bitmap_erase_copy_commands.sv =====
// ----------------------------------------------------------------------------
// Page bitmap erase/copy command generator
// Turns a page bitmap, one byte per transaction, into flash erase and
// page copy commands.
// ----------------------------------------------------------------------------
// The cfg channel writes the region start, region end and copy source
// registers; it is always ready and should only be used between passes.
// The item channel takes one bitmap byte per transaction with its opcode
// and a last-byte mark. A byte is classified in the cycle it is accepted
// and waits in a two-entry queue until the issuer takes it.
// The issuer walks the eight page bits of a byte at one bit per cycle while
// the cmd channel does not stall it, plus a flush step when the last erase
// byte flushes an open run. Each command goes out on the cmd channel from an
// output register, at most one per cycle, after the byte has passed through
// the queue; last_of_item marks the final command of a byte.
// When the receiver stalls, the issuer holds its current bit and the queue
// keeps accepting until it holds two bytes, then the item channel drops
// ready. Reset empties the queue and the output register, ends any pass
// and clears all three registers.
// ----------------------------------------------------------------------------
module page_bitmap_erase_copy_commands
(
    input  logic       clk,
    input  logic       rst_n,
    pbec_cfg_if.sink   cfg,
    pbec_item_if.sink  item,
    pbec_cmd_if.source cmd
);

    logic [pbec_pkg::ADDR_W-1:0] region_start_reg;
    logic [pbec_pkg::ADDR_W-1:0] region_end_reg;
    logic [pbec_pkg::ADDR_W-1:0] copy_source_reg;
    logic                        push_valid;
    logic                        push_ready;
    pbec_pkg::entry_t            push_entry;
    logic                        head_valid;
    logic                        head_pop;
    pbec_pkg::entry_t            head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= '0;
            copy_source_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                pbec_pkg::REG_REGION_START:
                begin
                    region_start_reg <= cfg.data;
                end
                pbec_pkg::REG_REGION_END:
                begin
                    region_end_reg <= cfg.data;
                end
                pbec_pkg::REG_COPY_SOURCE:
                begin
                    copy_source_reg <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    pbec_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .start_page (region_start_reg[pbec_pkg::ADDR_W-1:pbec_pkg::PAGE_SHIFT]),
        .end_page   (region_end_reg[pbec_pkg::ADDR_W-1:pbec_pkg::PAGE_SHIFT]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    pbec_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head       (head)
    );

    pbec_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .head_pop     (head_pop),
        .region_start (region_start_reg),
        .region_end   (region_end_reg),
        .copy_source  (copy_source_reg),
        .cmd          (cmd)
    );

endmodule
